@@ rtl/core/cafc_pkg.sv @@
// shared types and constants for the flag alu core
// no dependencies
`default_nettype none
package cafc_pkg;
    typedef enum logic [4:0] {
        K_ADD = 5'd0, K_ADDX = 5'd1, K_SUB = 5'd2, K_SUBX = 5'd3, K_NEG = 5'd4,
        K_NEGX = 5'd5, K_CMP = 5'd6, K_AND = 5'd7, K_OR = 5'd8, K_EOR = 5'd9,
        K_NOT = 5'd10, K_CLR = 5'd11, K_TST = 5'd12, K_ASL = 5'd13, K_ASR = 5'd14,
        K_LSL = 5'd15, K_LSR = 5'd16, K_ROL = 5'd17, K_ROR = 5'd18, K_ROXL = 5'd19,
        K_ROXR = 5'd20, K_MULU = 5'd21, K_MULS = 5'd22, K_DIVU = 5'd23,
        K_DIVS = 5'd24, K_ABCD = 5'd25, K_SBCD = 5'd26, K_NBCD = 5'd27,
        K_TCC = 5'd28
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE, S_SHIFT, S_DIV, S_DIVFIX, S_DONE, S_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic shift_step;
        logic div_step;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_shift;
        logic is_div;
        logic cnt_zero;
        logic div_last;
    } sts_t;

    localparam int DivSteps = 32;
endpackage
`default_nettype wire

@@ rtl/core/cafc_ctrl.sv @@
// sequencing state machine for the flag alu core
// depends on cafc_pkg
`default_nettype none
module cafc_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_fire,
    input  wire logic          out_fire,
    input  cafc_pkg::sts_t     sts,
    output cafc_pkg::cmd_t     cmd,
    output logic               busy,
    output logic               out_valid
);
    import cafc_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        busy = 1'b1;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                busy = 1'b0;
                if (in_fire) begin
                    cmd.load = 1'b1;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (sts.is_shift && !sts.cnt_zero) cmd.shift_step = 1'b1;
                else if (sts.is_div) state_next = S_DIV;
                else state_next = S_DONE;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) state_next = S_DONE;
            end
            S_DIVFIX: state_next = S_DONE;
            S_DONE: begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                out_valid = 1'b1;
                if (out_fire) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/core/cafc_dp.sv @@
// datapath: operand registers, serial shifter, restoring divider, flags
// depends on cafc_pkg
`default_nettype none
module cafc_dp (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  cafc_pkg::cmd_t     cmd,
    output cafc_pkg::sts_t     sts,
    input  wire logic [4:0]    kind,
    input  wire logic [1:0]    op_size,
    input  wire logic [31:0]   src,
    input  wire logic [31:0]   dst,
    input  wire logic [5:0]    shift_count,
    input  wire logic [3:0]    condition,
    output logic [31:0]        result,
    output logic [4:0]         flags,
    output logic               condition_true,
    output logic               divide_by_zero
);
    import cafc_pkg::*;

    logic [4:0]  kind_reg;
    logic [31:0] mask_reg, msb_reg, s_reg, d_reg, s32_reg, d32_reg;
    logic [5:0]  cnt_reg, cnt0_reg;
    logic [3:0]  cond_reg;
    logic [31:0] v_reg;
    logic        carry_reg, ovf_reg, xs_reg, sign_reg;
    logic [31:0] rem_reg, quo_reg, dvs_reg;
    logic [5:0]  dcnt_reg;
    logic        nd_reg, ns_reg;
    logic        fx_reg, fn_reg, fz_reg, fv_reg, fc_reg;
    logic [31:0] res_reg;
    logic        dbz_reg;

    logic [31:0] mask_w;
    logic [31:0] vn;
    logic        hi, lo;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;

    always_comb begin
        unique case (op_size)
            2'd0: mask_w = 32'h0000_00ff;
            2'd1: mask_w = 32'h0000_ffff;
            default: mask_w = 32'hffff_ffff;
        endcase
    end

    assign hi = |(v_reg & msb_reg);
    assign lo = v_reg[0];

    always_comb begin
        unique case (kind_reg)
            K_ASL, K_LSL: vn = (v_reg << 1) & mask_reg;
            K_ASR: vn = ((v_reg >> 1) | (sign_reg ? msb_reg : 32'd0)) & mask_reg;
            K_LSR: vn = v_reg >> 1;
            K_ROL: vn = ((v_reg << 1) | {31'd0, hi}) & mask_reg;
            K_ROR: vn = (v_reg >> 1) | (lo ? msb_reg : 32'd0);
            K_ROXL: vn = ((v_reg << 1) | {31'd0, xs_reg}) & mask_reg;
            default: vn = (v_reg >> 1) | (xs_reg ? msb_reg : 32'd0);
        endcase
    end

    assign rem_sh = {rem_reg, quo_reg[31]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    assign sts.is_shift = kind_reg >= K_ASL && kind_reg <= K_ROXR;
    assign sts.is_div = (kind_reg == K_DIVU || kind_reg == K_DIVS) && s32_reg[15:0] != 16'd0;
    assign sts.cnt_zero = cnt_reg == 6'd0;
    assign sts.div_last = dcnt_reg == 6'(DivSteps - 1);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= kind;
            mask_reg <= mask_w;
            msb_reg <= mask_w ^ (mask_w >> 1);
            s_reg <= src & mask_w;
            d_reg <= dst & mask_w;
            s32_reg <= src;
            d32_reg <= dst;
            cnt_reg <= shift_count;
            cnt0_reg <= shift_count;
            cond_reg <= condition;
            v_reg <= dst & mask_w;
            sign_reg <= |(dst & (mask_w ^ (mask_w >> 1)));
            carry_reg <= 1'b0;
            ovf_reg <= 1'b0;
            xs_reg <= fx_reg;
            dcnt_reg <= '0;
            rem_reg <= '0;
            nd_reg <= kind == K_DIVS && dst[31];
            ns_reg <= kind == K_DIVS && src[15];
            quo_reg <= (kind == K_DIVS && dst[31]) ? 32'd0 - dst : dst;
            dvs_reg <= {16'd0, (kind == K_DIVS && src[15]) ? 16'd0 - src[15:0] : src[15:0]};
        end
        if (cmd.shift_step) begin
            v_reg <= vn;
            cnt_reg <= cnt_reg - 6'd1;
            if (kind_reg == K_ASL && ((v_reg ^ vn) & msb_reg) != 32'd0) ovf_reg <= 1'b1;
            if (kind_reg == K_ROXL) xs_reg <= hi;
            else if (kind_reg == K_ROXR) xs_reg <= lo;
            else if (kind_reg == K_ASR || kind_reg == K_LSR || kind_reg == K_ROR)
                carry_reg <= lo;
            else carry_reg <= hi;
        end
        if (cmd.div_step) begin
            dcnt_reg <= dcnt_reg + 6'd1;
            if (!rem_sub[32]) begin
                rem_reg <= rem_sub[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[31:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    // final flag and result update
    logic [31:0] r;
    logic        nx, nn, nz, nv, nc, dbz;
    logic [32:0] sum;
    logic [31:0] xi;
    logic        ovf;
    logic [31:0] q, rm;
    logic [15:0] ma, mb;
    logic [31:0] prod;
    logic [5:0]  blo;
    logic [9:0]  bt;
    logic signed [6:0] slo;
    logic signed [9:0] shi, st;
    logic [7:0]  ba, bb;

    always_comb begin
        r = '0; nx = fx_reg; nn = fn_reg; nz = fz_reg; nv = fv_reg; nc = fc_reg;
        dbz = 1'b0; sum = '0; ovf = 1'b0; q = '0; rm = '0; ma = '0; mb = '0;
        prod = '0; blo = '0; bt = '0; slo = '0; shi = '0; st = '0; ba = '0; bb = '0;
        xi = (kind_reg == K_ADDX || kind_reg == K_SUBX || kind_reg == K_NEGX)
            ? {31'd0, fx_reg} : 32'd0;
        unique case (kind_reg)
            K_ADD, K_ADDX: begin
                sum = {1'b0, s_reg} + {1'b0, d_reg} + {1'b0, xi};
                r = sum[31:0] & mask_reg;
                nc = sum > {1'b0, mask_reg}; nx = nc;
                nv = ((s_reg ^ r) & (d_reg ^ r) & msb_reg) != 0;
                nn = (r & msb_reg) != 0;
                if (kind_reg == K_ADD) nz = r == 0; else if (r != 0) nz = 1'b0;
            end
            K_SUB, K_SUBX, K_CMP: begin
                r = (d_reg - s_reg - xi) & mask_reg;
                nc = ({1'b0, s_reg} + {1'b0, xi}) > {1'b0, d_reg};
                if (kind_reg != K_CMP) nx = nc;
                nv = ((d_reg ^ s_reg) & (d_reg ^ r) & msb_reg) != 0;
                nn = (r & msb_reg) != 0;
                if (kind_reg != K_SUBX) nz = r == 0; else if (r != 0) nz = 1'b0;
                if (kind_reg == K_CMP) r = '0;
            end
            K_NEG, K_NEGX: begin
                r = (32'd0 - d_reg - xi) & mask_reg;
                nc = d_reg != 0 || xi != 0; nx = nc;
                nv = (d_reg & r & msb_reg) != 0;
                nn = (r & msb_reg) != 0;
                if (kind_reg == K_NEG) nz = r == 0; else if (r != 0) nz = 1'b0;
            end
            K_AND, K_OR, K_EOR, K_NOT, K_CLR, K_TST: begin
                if (kind_reg == K_AND) r = s_reg & d_reg;
                else if (kind_reg == K_OR) r = s_reg | d_reg;
                else if (kind_reg == K_EOR) r = s_reg ^ d_reg;
                else if (kind_reg == K_NOT) r = ~d_reg & mask_reg;
                else if (kind_reg == K_CLR) r = '0;
                else r = d_reg;
                nn = (r & msb_reg) != 0; nz = r == 0; nv = 1'b0; nc = 1'b0;
                if (kind_reg == K_TST) r = '0;
            end
            K_ASL, K_ASR, K_LSL, K_LSR, K_ROL, K_ROR, K_ROXL, K_ROXR: begin
                r = v_reg;
                if (kind_reg == K_ROXL || kind_reg == K_ROXR) begin
                    nc = xs_reg; nx = xs_reg;
                end else begin
                    nc = cnt0_reg != 0 ? carry_reg : 1'b0;
                    if (kind_reg <= K_LSR && cnt0_reg != 0) nx = carry_reg;
                end
                nv = ovf_reg;
                nn = (r & msb_reg) != 0; nz = r == 0;
            end
            K_MULU, K_MULS: begin
                if (kind_reg == K_MULU) begin
                    prod = 32'(s32_reg[15:0]) * 32'(d32_reg[15:0]);
                    r = prod;
                end else begin
                    ma = s32_reg[15] ? 16'd0 - s32_reg[15:0] : s32_reg[15:0];
                    mb = d32_reg[15] ? 16'd0 - d32_reg[15:0] : d32_reg[15:0];
                    prod = {s32_reg[15] && ma == 0, 15'd0, ma}
                           * {d32_reg[15] && mb == 0, 15'd0, mb};
                    r = (s32_reg[15] != d32_reg[15]) ? 32'd0 - prod : prod;
                end
                nn = r[31]; nz = r == 0; nv = 1'b0; nc = 1'b0;
            end
            K_DIVU, K_DIVS: begin
                if (s32_reg[15:0] == 16'd0) begin
                    dbz = 1'b1; r = d32_reg;
                end else begin
                    q = quo_reg; rm = rem_reg;
                    if (kind_reg == K_DIVU) ovf = q > 32'h0000_ffff;
                    else ovf = (nd_reg != ns_reg) ? q > 32'd32768 : q > 32'd32767;
                    if (nd_reg != ns_reg) q = 32'd0 - q;
                    if (nd_reg) rm = 32'd0 - rm;
                    if (ovf) begin
                        nv = 1'b1; nc = 1'b0; r = d32_reg;
                    end else begin
                        r = {rm[15:0], q[15:0]};
                        nn = q[15]; nz = q[15:0] == 16'd0; nv = 1'b0; nc = 1'b0;
                    end
                end
            end
            K_ABCD: begin
                ba = s32_reg[7:0]; bb = d32_reg[7:0];
                blo = {2'd0, bb[3:0]} + {2'd0, ba[3:0]} + {5'd0, fx_reg};
                if (blo > 6'h09) blo = blo + 6'h06;
                bt = {2'd0, bb[7:4], 4'd0} + {2'd0, ba[7:4], 4'd0} + {4'd0, blo};
                nc = 1'b0;
                if (bt > 10'h099) begin
                    bt = bt + 10'h060; nc = 1'b1;
                end
                nx = nc;
                r = {24'd0, bt[7:0]};
                if (r != 0) nz = 1'b0;
            end
            K_SBCD, K_NBCD: begin
                ba = kind_reg == K_SBCD ? s32_reg[7:0] : d32_reg[7:0];
                bb = kind_reg == K_SBCD ? d32_reg[7:0] : 8'd0;
                slo = 7'(signed'({3'd0, bb[3:0]})) - 7'(signed'({3'd0, ba[3:0]}))
                      - 7'(signed'({6'd0, fx_reg}));
                shi = 10'(signed'({2'd0, bb[7:4], 4'd0})) - 10'(signed'({2'd0, ba[7:4], 4'd0}));
                if (slo < 0) begin
                    slo = slo + 7'sd10; shi = shi - 10'sd16;
                end
                st = shi + 10'(slo);
                nc = 1'b0;
                if (st < 0) begin
                    st = st + 10'sd160; nc = 1'b1;
                end
                nx = nc;
                r = {24'd0, st[7:0]};
                if (r != 0) nz = 1'b0;
            end
            default: r = '0;
        endcase
    end

    logic ct;
    always_comb begin
        unique case (cond_reg)
            4'd0: ct = 1'b1;
            4'd1: ct = 1'b0;
            4'd2: ct = !nc && !nz;
            4'd3: ct = nc || nz;
            4'd4: ct = !nc;
            4'd5: ct = nc;
            4'd6: ct = !nz;
            4'd7: ct = nz;
            4'd8: ct = !nv;
            4'd9: ct = nv;
            4'd10: ct = !nn;
            4'd11: ct = nn;
            4'd12: ct = nn == nv;
            4'd13: ct = nn != nv;
            4'd14: ct = !nz && (nn == nv);
            default: ct = nz || (nn != nv);
        endcase
    end

    logic ct_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            {fx_reg, fn_reg, fz_reg, fv_reg, fc_reg} <= '0;
        end else if (cmd.finish) begin
            {fx_reg, fn_reg, fz_reg, fv_reg, fc_reg} <= {nx, nn, nz, nv, nc};
        end
        if (cmd.finish) begin
            res_reg <= r;
            dbz_reg <= dbz;
            ct_reg <= ct;
        end
    end

    assign result = res_reg;
    assign flags = {fx_reg, fn_reg, fz_reg, fv_reg, fc_reg};
    assign condition_true = ct_reg;
    assign divide_by_zero = dbz_reg;
endmodule
`default_nettype wire

@@ rtl/core/cisc_alu_with_condition_flags_core.sv @@
// top level of the flag alu core
// depends on cafc_pkg, cafc_ctrl, cafc_dp
//
// one operation word enters on the s_ stream, one result word leaves on m_
// s_axis_tdata holds kind, op_size, src, dst, shift_count, condition
// m_axis_tdata holds result and the x n z v c flags, condition_true, divide_by_zero
// the x n z v c flags persist between operations; reset clears them
// the core handles one word at a time: s_axis_tready is high only when idle
// a word passes the idle, shift, div (nonzero divides only), done and out states;
//   shifts and rotates step once per unit of shift count in the shift state, and
//   the restoring divider in the div state gives one quotient bit per cycle
// the next word enters the cycle after the result word leaves
// the result word holds in the output register while m_axis_tready is low
// reset returns the controller to idle and drops m_axis_tvalid
`default_nettype none
module cisc_alu_with_condition_flags_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // kind[4:0] op_size[6:5] src[38:7] dst[70:39] shift_count[76:71] condition[80:77]
    input  wire logic [87:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // result[31:0] flag_x[32] flag_n[33] flag_z[34] flag_v[35] flag_c[36]
    // condition_true[37] divide_by_zero[38]
    output logic [39:0]      m_axis_tdata
);
    import cafc_pkg::*;

    cmd_t        cmd;
    sts_t        sts;
    logic        busy;
    logic [31:0] result;
    logic [4:0]  flags;
    logic        ct, dbz;

    cafc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_fire(s_axis_tvalid && s_axis_tready),
        .out_fire(m_axis_tvalid && m_axis_tready),
        .sts(sts), .cmd(cmd), .busy(busy), .out_valid(m_axis_tvalid)
    );

    cafc_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .kind(s_axis_tdata[4:0]), .op_size(s_axis_tdata[6:5]),
        .src(s_axis_tdata[38:7]), .dst(s_axis_tdata[70:39]),
        .shift_count(s_axis_tdata[76:71]), .condition(s_axis_tdata[80:77]),
        .result(result), .flags(flags), .condition_true(ct), .divide_by_zero(dbz)
    );

    assign s_axis_tready = !busy;
    assign m_axis_tdata = {1'b0, dbz, ct, flags[0], flags[1], flags[2], flags[3],
                           flags[4], result};
endmodule
`default_nettype wire
